FILE: src/cpf_pkg.sv
package cpf_pkg;

  localparam int BYTE_W = 8;
  localparam int TYPE_W = 32;
  localparam int LEN_W  = 31;
  localparam int CRC_W  = 32;

  // Length word plus type word: eight bytes of chunk header
  localparam int HDR_BYTES = 8;
  localparam int HDR_W     = HDR_BYTES * BYTE_W;
  localparam int CNT_W     = $clog2(HDR_BYTES + 1);

  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;
  localparam logic [CRC_W-1:0] CRC_ONES = 32'hFFFFFFFF;

  // Byte-fold masks, top bit goes out first
  localparam logic [HDR_BYTES-1:0] FOLD_TYPE = 8'h0F;
  localparam logic [HDR_BYTES-1:0] FOLD_DATA = 8'h80;

  typedef enum logic {
    OP_START = 1'b0,
    OP_DATA  = 1'b1
  } op_t;

  typedef enum logic {
    PH_PAYLOAD = 1'b0,
    PH_CRC     = 1'b1
  } phase_t;

  // One queued job: payload bytes to send, which of them fold into the CRC,
  // and whether the inverted CRC follows
  typedef struct packed {
    logic [HDR_W-1:0]     bytes;
    logic [HDR_BYTES-1:0] fold;
    logic [CNT_W-1:0]     count;
    logic                 tail;
    logic                 err;
  } job_t;

  // Reflected CRC-32 update by one byte
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: src/cpf_intake.sv
module cpf_intake
  import cpf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              operation,
  input  logic [TYPE_W-1:0] chunk_type,
  input  logic [LEN_W-1:0]  chunk_length,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              job_ready,
  output logic              job_load,
  output job_t              job_next
);

  logic             chunk_open;
  logic             chunk_open_next;
  logic [LEN_W-1:0] bytes_remaining;
  logic [LEN_W-1:0] bytes_remaining_next;

  assign in_stall = !job_ready;
  assign job_load = in_valid && !in_stall;

  // Decode the word into a job and the new chunk state
  always_comb begin
    job_next             = '0;
    job_next.count       = CNT_W'(1);
    job_next.err         = 1'b1;
    chunk_open_next      = chunk_open;
    bytes_remaining_next = bytes_remaining;
    if (op_t'(operation) == OP_START) begin
      if (!chunk_open) begin
        job_next.bytes       = {1'b0, chunk_length, chunk_type};
        job_next.fold        = FOLD_TYPE;
        job_next.count       = CNT_W'(HDR_BYTES);
        job_next.err         = 1'b0;
        job_next.tail        = (chunk_length == '0);
        chunk_open_next      = (chunk_length != '0);
        bytes_remaining_next = chunk_length;
      end
    end else if (chunk_open) begin
      job_next.bytes       = {data_byte, {(HDR_W-BYTE_W){1'b0}}};
      job_next.fold        = FOLD_DATA;
      job_next.err         = 1'b0;
      job_next.tail        = (bytes_remaining == LEN_W'(1));
      chunk_open_next      = (bytes_remaining != LEN_W'(1));
      bytes_remaining_next = bytes_remaining - LEN_W'(1);
    end
  end

  // Advance chunk state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_open      <= 1'b0;
      bytes_remaining <= '0;
    end else if (job_load) begin
      chunk_open      <= chunk_open_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

endmodule

FILE: src/cpf_emitter.sv
module cpf_emitter
  import cpf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              job_load,
  input  job_t              job_next,
  output logic              job_ready,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_byte,
  output logic              run_last,
  output logic              chunk_done,
  output logic              item_error
);

  phase_t           phase;
  phase_t           phase_next;
  logic             busy;
  job_t             job;
  logic [1:0]       crc_idx;
  logic [CRC_W-1:0] crc;
  logic [CRC_W-1:0] crc_inv;

  logic              out_free;
  logic              emit;
  logic              last_pay;
  logic              finishing;
  logic [BYTE_W-1:0] emit_byte;
  logic              emit_last;
  logic              emit_done;

  assign out_free = !out_valid || !out_stall;
  assign emit     = busy && out_free;
  assign last_pay = (job.count == CNT_W'(1));
  assign crc_inv  = crc ^ CRC_ONES;

  // Pick the byte for this cycle and the phase after it
  always_comb begin
    phase_next = phase;
    emit_byte  = job.bytes[HDR_W-1 -: BYTE_W];
    emit_last  = 1'b0;
    emit_done  = 1'b0;
    finishing  = 1'b0;
    unique case (phase)
      PH_PAYLOAD: begin
        emit_last = last_pay && !job.tail;
        finishing = emit && emit_last;
        if (emit && last_pay && job.tail) begin
          phase_next = PH_CRC;
        end
      end
      PH_CRC: begin
        emit_byte = BYTE_W'(crc_inv >> {~crc_idx, 3'b000});
        emit_last = (crc_idx == 2'd3);
        emit_done = emit_last;
        finishing = emit && emit_last;
        if (finishing) begin
          phase_next = PH_PAYLOAD;
        end
      end
      default: begin
        phase_next = PH_PAYLOAD;
      end
    endcase
    if (job_load) begin
      phase_next = PH_PAYLOAD;
    end
  end

  assign job_ready = !busy || finishing;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_PAYLOAD;
    end else begin
      phase <= phase_next;
    end
  end

  // Hold the job, shift out payload bytes, fold them into the CRC
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      job     <= '0;
      crc_idx <= '0;
      crc     <= CRC_ONES;
    end else begin
      if (emit) begin
        if (phase == PH_PAYLOAD) begin
          if (job.fold[HDR_BYTES-1]) begin
            crc <= crc_byte(crc, emit_byte);
          end
          if (!job_load) begin
            job.bytes <= job.bytes << BYTE_W;
            job.fold  <= job.fold << 1;
            job.count <= job.count - CNT_W'(1);
          end
          crc_idx <= '0;
        end else begin
          crc_idx <= crc_idx + 2'd1;
          if (emit_last) begin
            crc <= CRC_ONES;
          end
        end
      end
      if (job_load) begin
        busy <= 1'b1;
        job  <= job_next;
      end else if (finishing) begin
        busy <= 1'b0;
      end
    end
  end

  // Output register: load a byte whenever the slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte   <= emit_byte;
      run_last   <= emit_last;
      chunk_done <= emit_done;
      item_error <= job.err && (phase == PH_PAYLOAD);
    end
  end

endmodule

FILE: src/png_chunk_framer_crc32_unit.sv
// PNG chunk framer. A start word (operation 0) emits the chunk length as
// four bytes, most significant first, then the four type bytes, and seeds
// the CRC-32 over the type; a data word (operation 1) passes its byte
// through and folds it into the CRC. After the last data byte, or straight
// after the header of a zero-length chunk, the inverted CRC follows as four
// bytes and chunk_done marks its final byte. run_last flags the last byte
// caused by each input word. A data word with no chunk open, or a start
// word inside an open chunk, gives one zero byte with item_error set and is
// otherwise dropped. The single byte-wide output sets the rate: one output
// byte per cycle unless stalled, so a data word gives one byte (five when
// it closes the chunk), a start word eight bytes (twelve for a zero-length
// chunk), and an error word one. The next input word is taken in the cycle
// the previous one sends its last byte; the output register holds a stalled
// byte, so a stalled output blocks the input after at most one more word.
module png_chunk_framer_crc32_unit
  import cpf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              operation,
  input  logic [TYPE_W-1:0] chunk_type,
  input  logic [LEN_W-1:0]  chunk_length,
  input  logic [BYTE_W-1:0] data_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_byte,
  output logic              run_last,
  output logic              chunk_done,
  output logic              item_error
);

  logic job_ready;
  logic job_load;
  job_t job_next;

  // Decode input words and track the open chunk
  cpf_intake u_intake (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .chunk_type   (chunk_type),
    .chunk_length (chunk_length),
    .data_byte    (data_byte),
    .job_ready    (job_ready),
    .job_load     (job_load),
    .job_next     (job_next)
  );

  // Serialize bytes, run the CRC, drive the output register
  cpf_emitter u_emitter (
    .clk        (clk),
    .rst        (rst),
    .job_load   (job_load),
    .job_next   (job_next),
    .job_ready  (job_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .chunk_done (chunk_done),
    .item_error (item_error)
  );

endmodule
